>>> design/msfs_pkg.sv
// msfs_pkg: shared widths, request codes, item and store entry types
// for the memory snapshot filter search block; depends on nothing
package msfs_pkg;

  localparam int unsigned REQ_W = 3;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CNT_W = 17;

  localparam int unsigned DEF_ADDR_BITS = 16;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;

  localparam logic [REQ_W-1:0] REQ_SNAPSHOT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SAME = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DIFF = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOWER = 3'd3;
  localparam logic [REQ_W-1:0] REQ_HIGHER = 3'd4;

  typedef enum logic [1:0] {
    OP_SNAP,
    OP_FILTER,
    OP_IGNORE
  } op_e;

  typedef enum logic [1:0] {
    CMP_SAME,
    CMP_DIFF,
    CMP_LOWER,
    CMP_HIGHER
  } cmp_e;

  typedef struct packed {
    op_e               op;
    cmp_e              cmp;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    logic              last;
  } item_t;

  typedef struct packed {
    logic              mark;
    logic [DATA_W-1:0] value;
  } entry_t;

endpackage

>>> design/msfs_in_if.sv
// msfs_in_if: valid/ready channel carrying one memory byte word
// depends on msfs_pkg for field widths
interface msfs_in_if;
  logic                         valid;
  logic                         ready;
  logic [msfs_pkg::REQ_W-1:0]   req_type;
  logic [msfs_pkg::ADDR_W-1:0]  byte_address;
  logic [msfs_pkg::DATA_W-1:0]  mem_value;
  logic                         last_of_pass;

  modport source (
    output valid, req_type, byte_address, mem_value, last_of_pass,
    input  ready
  );
  modport sink (
    input  valid, req_type, byte_address, mem_value, last_of_pass,
    output ready
  );
endinterface

>>> design/msfs_out_if.sv
// msfs_out_if: valid/ready channel carrying one search result word
// depends on msfs_pkg for field widths
interface msfs_out_if;
  logic                         valid;
  logic                         ready;
  logic [msfs_pkg::ADDR_W-1:0]  out_address;
  logic                         still_candidate;
  logic [msfs_pkg::DATA_W-1:0]  kept_value;
  logic [msfs_pkg::CNT_W-1:0]   match_count;
  logic                         pass_done;

  modport source (
    output valid, out_address, still_candidate, kept_value, match_count, pass_done,
    input  ready
  );
  modport sink (
    input  valid, out_address, still_candidate, kept_value, match_count, pass_done,
    output ready
  );
endinterface

>>> design/msfs_front.sv
// msfs_front: accepts input words, decodes the request code and queues
// classified items for the back end; depends on msfs_pkg, msfs_in_if
module msfs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  msfs_in_if.sink         req_i,
  output msfs_pkg::item_t q_item_o,
  output logic            q_valid_o,
  input  logic            q_pop_i
);
  import msfs_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  item_t             slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     fill_q, fill_d;
  item_t             cls;
  logic              push;

  // request decode
  always_comb begin
    cls.addr  = req_i.byte_address;
    cls.value = req_i.mem_value;
    cls.last  = req_i.last_of_pass;
    cls.op    = OP_IGNORE;
    cls.cmp   = CMP_SAME;
    unique case (req_i.req_type)
      REQ_SNAPSHOT: cls.op = OP_SNAP;
      REQ_SAME: begin
        cls.op  = OP_FILTER;
        cls.cmp = CMP_SAME;
      end
      REQ_DIFF: begin
        cls.op  = OP_FILTER;
        cls.cmp = CMP_DIFF;
      end
      REQ_LOWER: begin
        cls.op  = OP_FILTER;
        cls.cmp = CMP_LOWER;
      end
      REQ_HIGHER: begin
        cls.op  = OP_FILTER;
        cls.cmp = CMP_HIGHER;
      end
      default: cls.op = OP_IGNORE;
    endcase
  end

  assign req_i.ready = (fill_q != (PtrW+1)'(QUEUE_DEPTH));
  assign push        = req_i.valid && req_i.ready;

  assign wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
  assign fill_d   = fill_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

  assign q_item_o  = slot_q[rd_ptr_q];
  assign q_valid_o = (fill_q != '0);

endmodule

>>> design/msfs_back.sv
// msfs_back: snapshot store, compare and write-back, pass counter and
// output register; depends on msfs_pkg, msfs_out_if
module msfs_back #(
  parameter int unsigned ADDR_BITS = msfs_pkg::DEF_ADDR_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  msfs_pkg::item_t q_item_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  msfs_out_if.source      rsp_o
);
  import msfs_pkg::*;

  localparam int unsigned Depth = 2 ** ADDR_BITS;

  entry_t              snap_mem [Depth];
  entry_t              rd_q;
  item_t               exe_q;
  logic                exe_v_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_now;
  logic                out_v_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic                out_mark_q;
  logic [DATA_W-1:0]   out_val_q;
  logic [CNT_W-1:0]    out_cnt_q;
  logic                out_last_q;

  logic [ADDR_BITS-1:0] rd_idx, exe_idx;
  logic                 exe_adv, exe_load, fwd;
  logic                 hit, bump;
  entry_t               new_ent;

  assign rd_idx  = ADDR_BITS'(q_item_i.addr);
  assign exe_idx = ADDR_BITS'(exe_q.addr);

  assign exe_adv  = exe_v_q && (!out_v_q || rsp_o.ready);
  assign exe_load = q_valid_i && (!exe_v_q || exe_adv);
  assign q_pop_o  = exe_load;
  assign fwd      = exe_adv && (exe_idx == rd_idx);

  always_comb begin
    unique case (exe_q.cmp)
      CMP_SAME:   hit = (exe_q.value == rd_q.value);
      CMP_DIFF:   hit = (exe_q.value != rd_q.value);
      CMP_LOWER:  hit = (exe_q.value < rd_q.value);
      CMP_HIGHER: hit = (exe_q.value > rd_q.value);
      default:    hit = 1'b0;
    endcase
  end

  always_comb begin
    new_ent = rd_q;
    bump    = 1'b0;
    unique case (exe_q.op)
      OP_SNAP: begin
        new_ent.mark  = 1'b1;
        new_ent.value = exe_q.value;
        bump          = 1'b1;
      end
      OP_FILTER: begin
        if (rd_q.mark) begin
          if (hit) begin
            new_ent.value = exe_q.value;
            bump          = 1'b1;
          end else begin
            new_ent.mark = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // saturating pass counter
  assign cnt_now = (bump && cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_d   = exe_q.last ? '0 : cnt_now;

  always_ff @(posedge clk_i) begin
    if (exe_adv) begin
      snap_mem[exe_idx] <= new_ent;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exe_load) begin
      rd_q <= fwd ? new_ent : snap_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (exe_load) begin
      exe_q <= q_item_i;
    end
    if (exe_adv) begin
      out_addr_q <= exe_q.addr;
      out_mark_q <= new_ent.mark;
      out_val_q  <= new_ent.value;
      out_cnt_q  <= cnt_now;
      out_last_q <= exe_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exe_v_q <= 1'b0;
      out_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (exe_load) begin
        exe_v_q <= 1'b1;
      end else if (exe_adv) begin
        exe_v_q <= 1'b0;
      end
      if (exe_adv) begin
        out_v_q <= 1'b1;
        cnt_q   <= cnt_d;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid           = out_v_q;
  assign rsp_o.out_address     = out_addr_q;
  assign rsp_o.still_candidate = out_mark_q;
  assign rsp_o.kept_value      = out_val_q;
  assign rsp_o.match_count     = out_cnt_q;
  assign rsp_o.pass_done       = out_last_q;

endmodule

>>> design/memory_snapshot_filter_search.sv
// memory_snapshot_filter_search: top level, front decode and queue feeding
// the store/compare back end; depends on msfs_pkg, msfs_in_if, msfs_out_if,
// msfs_front, msfs_back
//
//   port    dir  word
//   req_i   in   req_type, byte_address, mem_value, last_of_pass
//   rsp_o   out  out_address, still_candidate, kept_value, match_count, pass_done
//
// one word in and one word out per cycle sustained while rsp_o.ready holds
// from input accept to result valid: queue slot, then store read at the
// queue head, then compare and write-back into the output register
// the single store port pair (one read, one write a cycle) sets the rate
// reset clears the queue, pipeline valids and pass counter, not the store
// a stalled output backs up into the four-entry queue, then drops req_i.ready
module memory_snapshot_filter_search #(
  parameter int unsigned ADDR_BITS = msfs_pkg::DEF_ADDR_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  msfs_in_if.sink     req_i,
  msfs_out_if.source  rsp_o
);
  import msfs_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  msfs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_item_o  (q_item),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  msfs_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_item_i  (q_item),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

`ifndef SYNTH
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !q_pop) |=> q_valid)
    else $error("queued word lost");

  a_count_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.ready && rsp_o.pass_done)
      |=> (!rsp_o.valid || rsp_o.match_count <= 17'd1))
    else $error("match count not cleared after pass end");
`endif

endmodule
